// File: src/ttc_pkg.sv
`default_nettype none
package ttc_pkg;

   localparam int WAITER_SLOTS_DEF = 8;
   localparam int SAMPLE_RATE_DEF  = 96000;

   localparam int TEMPO_W    = 10;
   localparam int TICK_W     = 32;
   localparam int PERIOD_W   = 17;
   localparam int CMD_W      = 2;
   localparam int PEND_OUT_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam int DIVD_W = 20;
   localparam int DIVS_W = 15;

   localparam int TEMPO_MIN   = 1;
   localparam int TEMPO_MAX   = 1000;
   localparam int SEC_PER_MIN = 60;
   localparam int RESET_BPM   = 120;
   localparam int RESET_PPQ   = 96;

   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_W     = 21;
   localparam int RECIP_SEC   = ((1 << RECIP_SHIFT) + SEC_PER_MIN - 1) / SEC_PER_MIN;
   localparam int RECIP_P_W   = DIVD_W + RECIP_W;

   localparam logic [CSR_IDX_W-1:0] REG_BPM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PPQ = 2'd1;

   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SETPOS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd2;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] S_SMP      = 4'd1;
   localparam logic [STEP_W-1:0] S_SCAN_RD  = 4'd2;
   localparam logic [STEP_W-1:0] S_SCAN_CMP = 4'd3;
   localparam logic [STEP_W-1:0] S_RESP     = 4'd4;
   localparam logic [STEP_W-1:0] S_SET      = 4'd5;
   localparam logic [STEP_W-1:0] S_REACH    = 4'd6;
   localparam logic [STEP_W-1:0] S_FULL     = 4'd7;
   localparam logic [STEP_W-1:0] S_STORE    = 4'd8;
   localparam logic [STEP_W-1:0] S_MUL      = 4'd9;
   localparam logic [STEP_W-1:0] S_DIV1     = 4'd10;
   localparam logic [STEP_W-1:0] S_WAIT1    = 4'd11;
   localparam logic [STEP_W-1:0] S_DIV2     = 4'd12;
   localparam logic [STEP_W-1:0] S_WAIT2    = 4'd13;
   localparam logic [STEP_W-1:0] S_LOAD     = 4'd14;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_IDLE,
      OP_SMP,
      OP_RELEASE,
      OP_RESP,
      OP_SET,
      OP_REACH,
      OP_FULL,
      OP_STORE,
      OP_MUL,
      OP_DIV1,
      OP_DIV2,
      OP_LOAD
   } op_type;

   typedef enum logic [3:0] {
      C_NEXT,
      C_GOTO,
      C_IDLE,
      C_NO_ADV,
      C_MORE,
      C_REACHED,
      C_FULL,
      C_UNTIL_FREE,
      C_UNTIL_DIV,
      C_UNTIL_OUT
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   jump;
   } uword_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic              csr_acc;
      logic              req_acc;
      logic [CMD_W-1:0]  cmd;
      logic              no_adv;
      logic              more;
      logic              reached;
      logic              full;
      logic              free;
      logic              div_done;
      logic              out_free;
   } stat_type;

   function automatic uword_type mk(op_type op, cond_type cond, logic [STEP_W-1:0] jump);
      uword_type w;
      w.op   = op;
      w.cond = cond;
      w.jump = jump;
      return w;
   endfunction

   function automatic uword_type ucode(logic [STEP_W-1:0] addr);
      uword_type w;
      case (addr)
         S_IDLE:     w = mk(OP_IDLE,    C_IDLE,       S_IDLE);
         S_SMP:      w = mk(OP_SMP,     C_NO_ADV,     S_RESP);
         S_SCAN_RD:  w = mk(OP_NOP,     C_NEXT,       S_IDLE);
         S_SCAN_CMP: w = mk(OP_RELEASE, C_MORE,       S_SCAN_RD);
         S_RESP:     w = mk(OP_RESP,    C_UNTIL_OUT,  S_IDLE);
         S_SET:      w = mk(OP_SET,     C_GOTO,       S_RESP);
         S_REACH:    w = mk(OP_REACH,   C_REACHED,    S_RESP);
         S_FULL:     w = mk(OP_FULL,    C_FULL,       S_RESP);
         S_STORE:    w = mk(OP_STORE,   C_UNTIL_FREE, S_RESP);
         S_MUL:      w = mk(OP_MUL,     C_NEXT,       S_IDLE);
         S_DIV1:     w = mk(OP_DIV1,    C_NEXT,       S_IDLE);
         S_WAIT1:    w = mk(OP_NOP,     C_UNTIL_DIV,  S_DIV2);
         S_DIV2:     w = mk(OP_DIV2,    C_NEXT,       S_IDLE);
         S_WAIT2:    w = mk(OP_NOP,     C_UNTIL_DIV,  S_LOAD);
         S_LOAD:     w = mk(OP_LOAD,    C_GOTO,       S_IDLE);
         default:    w = mk(OP_NOP,     C_GOTO,       S_IDLE);
      endcase
      return w;
   endfunction

   function automatic logic [STEP_W-1:0] dispatch(logic [CMD_W-1:0] cmd);
      logic [STEP_W-1:0] s;
      case (cmd)
         CMD_SAMPLE: s = S_SMP;
         CMD_SETPOS: s = S_SET;
         CMD_WAIT:   s = S_REACH;
         default:    s = S_RESP;
      endcase
      return s;
   endfunction

   function automatic logic [TEMPO_W-1:0] clamp_tempo(logic [TEMPO_W-1:0] v);
      logic [TEMPO_W-1:0] r;
      if (v < TEMPO_W'(TEMPO_MIN)) begin
         r = TEMPO_W'(TEMPO_MIN);
      end else if (v > TEMPO_W'(TEMPO_MAX)) begin
         r = TEMPO_W'(TEMPO_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: src/tempo_tick_clock_with_waiters_core.sv
`default_nettype none
// Tempo tick clock with waiter table. A small microcoded sequencer steps a
// plain datapath through one item at a time and returns exactly one result per
// item through an output register, so the next item is taken while a result
// still waits; a result that cannot leave holds the sequencer in its response
// step. A sample that does not advance the tick goes straight to its response;
// one that advances it first runs the release scan, which reads each stored
// target in turn from the single-port target RAM. A set-position item sets the
// tick and is answered, and an unused command is answered as it is. A wait item
// is answered without being stored when its target is already reached or the
// table is full, and is otherwise stored in the lowest free slot, searched one
// slot a cycle. Each configuration write recomputes the period: the divide by
// 60 is a reciprocal multiply, and the sample rate is then divided by that in a
// restoring divider, one quotient bit per cycle; no item and no further write
// is taken until the new period is loaded.
module tempo_tick_clock_with_waiters_core #(
   parameter int WAITER_SLOTS = ttc_pkg::WAITER_SLOTS_DEF,
   parameter int SAMPLE_RATE  = ttc_pkg::SAMPLE_RATE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tick_value [31:0]
   input  wire logic [ttc_pkg::REQ_DATA_W-1:0] req_tdata,
   // command [1:0]
   input  wire logic [ttc_pkg::CMD_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tick_now [31:0], tick_advanced [32], released [33],
   // waiters_pending [37:34], rejected [38], zero [39]
   output logic      [ttc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ttc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ttc_pkg::TEMPO_W-1:0]    csr_data
);
   import ttc_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   ttc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   ttc_dp #(
      .WAITER_SLOTS (WAITER_SLOTS),
      .SAMPLE_RATE  (SAMPLE_RATE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule
`default_nettype wire

// File: src/ttc_ram.sv
`default_nettype none
module ttc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/ttc_div.sv
`default_nettype none
module ttc_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ttc_pkg::DIVD_W-1:0] dividend,
   input  wire logic [ttc_pkg::DIVS_W-1:0] divisor,
   output logic      [ttc_pkg::DIVD_W-1:0] quotient,
   output logic                            done
);
   import ttc_pkg::*;

   localparam int CNTW = $clog2(DIVD_W + 1);

   logic [DIVD_W-1:0] dvd_ff, dvd_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DIVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNTW'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
         dvd_in  = {dvd_ff[DIVD_W-2:0], ge};
         cnt_in  = cnt_ff - CNTW'(1);
         busy_in = cnt_ff != CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign quotient = dvd_ff;
   assign done     = !busy_ff;

endmodule
`default_nettype wire

// File: src/ttc_seq.sv
`default_nettype none
module ttc_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ttc_pkg::stat_type stat,
   output ttc_pkg::ctrl_type      ctrl
);
   import ttc_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] step_inc;
   uword_type         uw;

   always_comb begin
      uw       = ucode(step_ff);
      step_inc = step_ff + STEP_W'(1);
      case (uw.cond)
         C_NEXT:       step_in = step_inc;
         C_GOTO:       step_in = uw.jump;
         C_IDLE: begin
            if (stat.csr_acc) begin
               step_in = S_MUL;
            end else if (stat.req_acc) begin
               step_in = dispatch(stat.cmd);
            end else begin
               step_in = step_ff;
            end
         end
         C_NO_ADV:     step_in = stat.no_adv   ? uw.jump : step_inc;
         C_MORE:       step_in = stat.more     ? uw.jump : step_inc;
         C_REACHED:    step_in = stat.reached  ? uw.jump : step_inc;
         C_FULL:       step_in = stat.full     ? uw.jump : step_inc;
         C_UNTIL_FREE: step_in = stat.free     ? uw.jump : step_ff;
         C_UNTIL_DIV:  step_in = stat.div_done ? uw.jump : step_ff;
         C_UNTIL_OUT:  step_in = stat.out_free ? uw.jump : step_ff;
         default:      step_in = S_IDLE;
      endcase
      ctrl.op = uw.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

// File: src/ttc_dp.sv
`default_nettype none
module ttc_dp #(
   parameter int WAITER_SLOTS = ttc_pkg::WAITER_SLOTS_DEF,
   parameter int SAMPLE_RATE  = ttc_pkg::SAMPLE_RATE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ttc_pkg::ctrl_type              ctrl,
   output ttc_pkg::stat_type                   stat,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [ttc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [ttc_pkg::CMD_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [ttc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ttc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ttc_pkg::TEMPO_W-1:0]    csr_data
);
   import ttc_pkg::*;

   localparam int IDXW      = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
   localparam int PENDW     = $clog2(WAITER_SLOTS + 1);
   localparam int RESET_DEN = (RESET_BPM * RESET_PPQ) / SEC_PER_MIN;
   localparam int RESET_PER = SAMPLE_RATE / ((RESET_DEN == 0) ? 1 : RESET_DEN);

   logic [TEMPO_W-1:0]      bpm_ff, bpm_in;
   logic [TEMPO_W-1:0]      ppq_ff, ppq_in;
   logic [PERIOD_W-1:0]     period_ff, period_in;
   logic [PERIOD_W-1:0]     sc_ff, sc_in;
   logic [TICK_W-1:0]       tick_ff, tick_in;
   logic [TICK_W-1:0]       value_ff, value_in;
   logic                    adv_ff, adv_in;
   logic                    rel_ff, rel_in;
   logic                    rej_ff, rej_in;
   logic [IDXW-1:0]         idx_ff, idx_in;
   logic [WAITER_SLOTS-1:0] valid_ff, valid_in;
   logic [PENDW-1:0]        pend_ff, pend_in;
   logic [DIVD_W-1:0]       prod_ff, prod_in;
   logic [DIVS_W-1:0]       persec_ff, persec_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [PERIOD_W:0]       sc_next;
   logic                    adv;
   logic                    csr_acc;
   logic                    req_acc;
   logic                    out_free;
   logic                    slot_free;
   logic                    ram_we;
   logic [TICK_W-1:0]       ram_rdata;
   logic                    div_start;
   logic [DIVD_W-1:0]       div_dividend;
   logic [DIVS_W-1:0]       div_divisor;
   logic [DIVD_W-1:0]       div_quot;
   logic                    div_done;
   logic [DIVS_W-1:0]       den;
   logic [RECIP_P_W-1:0]    recip_prod;

   ttc_ram #(
      .WIDTH (TICK_W),
      .DEPTH (WAITER_SLOTS)
   ) u_target_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (idx_ff),
      .wr_data (value_ff),
      .rd_data (ram_rdata)
   );

   ttc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .done     (div_done)
   );

   assign csr_ready  = ctrl.op == OP_IDLE;
   assign req_tready = (ctrl.op == OP_IDLE) && !csr_valid;
   assign csr_acc    = csr_valid && csr_ready;
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign slot_free  = !valid_ff[idx_ff];
   assign sc_next    = {1'b0, sc_ff} + (PERIOD_W + 1)'(1);
   assign adv        = sc_next > {1'b0, period_ff};

   assign recip_prod   = RECIP_P_W'(prod_ff) * RECIP_P_W'(RECIP_SEC);
   assign den          = (persec_ff == '0) ? DIVS_W'(1) : persec_ff;
   assign div_start    = ctrl.op == OP_DIV2;
   assign div_dividend = DIVD_W'(SAMPLE_RATE);
   assign div_divisor  = den;

   always_comb begin
      stat.csr_acc  = csr_acc;
      stat.req_acc  = req_acc;
      stat.cmd      = req_tuser;
      stat.no_adv   = !adv;
      stat.more     = idx_ff != IDXW'(WAITER_SLOTS - 1);
      stat.reached  = value_ff <= tick_ff;
      stat.full     = pend_ff == PENDW'(WAITER_SLOTS);
      stat.free     = slot_free;
      stat.div_done = div_done;
      stat.out_free = out_free;
   end

   always_comb begin
      bpm_in       = bpm_ff;
      ppq_in       = ppq_ff;
      period_in    = period_ff;
      sc_in        = sc_ff;
      tick_in      = tick_ff;
      value_in     = value_ff;
      adv_in       = adv_ff;
      rel_in       = rel_ff;
      rej_in       = rej_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      prod_in      = prod_ff;
      persec_in    = persec_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      ram_we       = 1'b0;
      case (ctrl.op)
         OP_IDLE: begin
            if (csr_acc) begin
               if (csr_index == REG_BPM) begin
                  bpm_in = clamp_tempo(csr_data);
               end else if (csr_index == REG_PPQ) begin
                  ppq_in = clamp_tempo(csr_data);
               end
            end else if (req_acc) begin
               value_in = req_tdata;
               adv_in   = 1'b0;
               rel_in   = 1'b0;
               rej_in   = 1'b0;
               idx_in   = '0;
            end
         end
         OP_SMP: begin
            if (adv) begin
               sc_in   = '0;
               tick_in = tick_ff + TICK_W'(1);
               adv_in  = 1'b1;
            end else begin
               sc_in = sc_next[PERIOD_W-1:0];
            end
         end
         OP_RELEASE: begin
            if (valid_ff[idx_ff] && (ram_rdata <= tick_ff)) begin
               valid_in[idx_ff] = 1'b0;
               pend_in          = pend_ff - PENDW'(1);
               rel_in           = 1'b1;
            end
            idx_in = idx_ff + IDXW'(1);
         end
         OP_SET: begin
            tick_in = value_ff;
         end
         OP_REACH: begin
            if (value_ff <= tick_ff) begin
               rel_in = 1'b1;
            end
         end
         OP_FULL: begin
            if (pend_ff == PENDW'(WAITER_SLOTS)) begin
               rej_in = 1'b1;
            end
         end
         OP_STORE: begin
            if (slot_free) begin
               valid_in[idx_ff] = 1'b1;
               pend_in          = pend_ff + PENDW'(1);
               ram_we           = 1'b1;
            end else begin
               idx_in = idx_ff + IDXW'(1);
            end
         end
         OP_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, rej_ff, PEND_OUT_W'(pend_ff), rel_ff, adv_ff, tick_ff};
            end
         end
         OP_MUL: begin
            prod_in = {{(DIVD_W - TEMPO_W){1'b0}}, bpm_ff} *
                      {{(DIVD_W - TEMPO_W){1'b0}}, ppq_ff};
         end
         OP_DIV1: begin
            persec_in = recip_prod[RECIP_SHIFT +: DIVS_W];
         end
         OP_LOAD: begin
            period_in = div_quot[PERIOD_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpm_ff       <= TEMPO_W'(RESET_BPM);
         ppq_ff       <= TEMPO_W'(RESET_PPQ);
         period_ff    <= PERIOD_W'(RESET_PER);
         sc_ff        <= '0;
         tick_ff      <= '0;
         valid_ff     <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bpm_ff       <= bpm_in;
         ppq_ff       <= ppq_in;
         period_ff    <= period_in;
         sc_ff        <= sc_in;
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      adv_ff      <= adv_in;
      rel_ff      <= rel_in;
      rej_ff      <= rej_in;
      idx_ff      <= idx_in;
      prod_ff     <= prod_in;
      persec_ff   <= persec_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: test/tempo_tick_clock_with_waiters_core_tb.sv
`timescale 1ns / 100ps
module tempo_tick_clock_with_waiters_core_tb;
   import ttc_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE3 = 2'd3;
   localparam int SLOTS      = WAITER_SLOTS_DEF;
   localparam int CYCLE_CAP  = 1000000;
   localparam int HOLD_LEN   = 400;

   typedef struct packed {
      logic [TICK_W-1:0]     tick;
      logic                  advanced;
      logic                  released;
      logic [PEND_OUT_W-1:0] pending;
      logic                  rejected;
   } tick_report_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [1:0]        code;
      logic [31:0]       value;
      logic [15:0]       reps;
      logic              typed;
      tick_report_type   want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TEMPO_W-1:0] csr_data = '0;

   tempo_tick_clock_with_waiters_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // tempo clock mirror
   logic [TEMPO_W-1:0]  m_bpm;
   logic [TEMPO_W-1:0]  m_ppq;
   logic [PERIOD_W-1:0] m_period;
   logic [PERIOD_W-1:0] m_samples;
   logic [TICK_W-1:0]   m_tick;
   logic                m_busy [SLOTS];
   logic [TICK_W-1:0]   m_target [SLOTS];

   tick_report_type tick_reports_due[$];
   stim_row_type    stim_rows[$];
   int failures = 0;
   int cycles = 0;
   int rx_mode = 0;
   int hold_asked = 0;
   int hold_done = 0;
   int hold_left = 0;
   int rx_count = 0;
   int burst_left = 0;
   bit tx_gapless = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [PERIOD_W-1:0] period_for(logic [TEMPO_W-1:0] bpm,
                                                     logic [TEMPO_W-1:0] ppq);
      int per_sec;
      per_sec = (int'(bpm) * int'(ppq)) / SEC_PER_MIN;
      if (per_sec == 0) per_sec = 1;
      return PERIOD_W'(SAMPLE_RATE_DEF / per_sec);
   endfunction

   function automatic logic [TEMPO_W-1:0] clip_tempo(logic [TEMPO_W-1:0] v);
      if (v < TEMPO_W'(TEMPO_MIN)) return TEMPO_W'(TEMPO_MIN);
      if (v > TEMPO_W'(TEMPO_MAX)) return TEMPO_W'(TEMPO_MAX);
      return v;
   endfunction

   function automatic void set_tempo_model(logic [CSR_IDX_W-1:0] idx,
                                           logic [TEMPO_W-1:0] data);
      if (idx == REG_BPM) m_bpm = clip_tempo(data);
      else if (idx == REG_PPQ) m_ppq = clip_tempo(data);
      else return;
      m_period = period_for(m_bpm, m_ppq);
   endfunction

   function automatic tick_report_type report(logic [TICK_W-1:0] tick, logic adv, logic rel,
                                              logic [PEND_OUT_W-1:0] pend, logic rej);
      tick_report_type r;
      r.tick = tick;
      r.advanced = adv;
      r.released = rel;
      r.pending = pend;
      r.rejected = rej;
      return r;
   endfunction

   function automatic tick_report_type compute_tick_report(logic [CMD_W-1:0] cmd,
                                                           logic [TICK_W-1:0] val);
      tick_report_type r;
      logic [PERIOD_W:0] next;
      logic stored;
      int n;
      r = '0;
      stored = 1'b0;
      n = 0;
      case (cmd)
         CMD_SAMPLE: begin
            next = {1'b0, m_samples} + 1'b1;
            if (next > {1'b0, m_period}) begin
               m_samples = '0;
               m_tick = m_tick + 1'b1;
               r.advanced = 1'b1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (m_busy[i] && m_target[i] <= m_tick) begin
                     m_busy[i] = 1'b0;
                     r.released = 1'b1;
                  end
               end
            end else begin
               m_samples = next[PERIOD_W-1:0];
            end
         end
         CMD_SETPOS: m_tick = val;
         CMD_WAIT: begin
            if (val <= m_tick) begin
               r.released = 1'b1;
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!stored && !m_busy[i]) begin
                     m_busy[i] = 1'b1;
                     m_target[i] = val;
                     stored = 1'b1;
                  end
               end
               if (!stored) r.rejected = 1'b1;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < SLOTS; i++) if (m_busy[i]) n++;
      r.tick = m_tick;
      r.pending = PEND_OUT_W'(n);
      return r;
   endfunction

   function automatic stim_row_type mk_row(row_kind_type kind, logic [1:0] code,
                                           logic [31:0] value, logic [15:0] reps,
                                           logic typed, tick_report_type want);
      stim_row_type s;
      s.kind = kind;
      s.code = code;
      s.value = value;
      s.reps = reps;
      s.typed = typed;
      s.want = want;
      return s;
   endfunction

   function automatic void add_row(stim_row_type s);
      stim_rows.insert(stim_rows.size(), s);
   endfunction

   // receiver: long hold-off on request, otherwise a per-phase stall pattern
   always @(negedge clock) begin
      rx_count <= rx_count + 1;
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
         hold_done <= hold_asked;
         hold_left <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((rx_count % 13) < 9);
         endcase
      end
   end

   always @(posedge clock) begin
      tick_report_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tick_reports_due.size() == 0) begin
            $error("result with nothing outstanding: %h", rsp_tdata);
            failures++;
         end else begin
            due = tick_reports_due.pop_front();
            if (rsp_tdata[31:0] !== due.tick) begin
               $error("tick_now expected %0h got %0h", due.tick, rsp_tdata[31:0]);
               failures++;
            end
            if (rsp_tdata[32] !== due.advanced) begin
               $error("tick_advanced expected %0d got %0d", due.advanced, rsp_tdata[32]);
               failures++;
            end
            if (rsp_tdata[33] !== due.released) begin
               $error("released expected %0d got %0d", due.released, rsp_tdata[33]);
               failures++;
            end
            if (rsp_tdata[37:34] !== due.pending) begin
               $error("waiters_pending expected %0d got %0d", due.pending, rsp_tdata[37:34]);
               failures++;
            end
            if (rsp_tdata[38] !== due.rejected) begin
               $error("rejected expected %0d got %0d", due.rejected, rsp_tdata[38]);
               failures++;
            end
         end
      end
   end

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [TICK_W-1:0] val, logic typed,
                            tick_report_type want);
      tick_report_type got;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= val;
      do @(posedge clock); while (!req_tready);
      got = compute_tick_report(cmd, val);
      tick_reports_due.insert(tick_reports_due.size(), typed ? want : got);
   endtask

   task automatic pace_sender();
      int gap;
      if (tx_gapless) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (tick_reports_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_tempo_reg(logic [CSR_IDX_W-1:0] idx, logic [TEMPO_W-1:0] data);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      set_tempo_model(idx, data);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic send_random_item();
      int r;
      logic [CMD_W-1:0] c;
      logic [TICK_W-1:0] v;
      r = $urandom_range(0, 99);
      v = $urandom;
      c = CMD_WAIT;
      if (r < 50) c = CMD_SAMPLE;
      else if (r < 62) v = m_tick + $urandom_range(1, 6);
      else if (r < 70) v = m_tick - $urandom_range(0, 3);
      else if (r < 76) v = m_tick + 32'h1000_0000 + ($urandom & 32'hFFFF);
      else if (r < 84) begin
         c = CMD_SETPOS;
         if ($urandom_range(0, 1) != 0) v = m_tick - $urandom_range(0, 8);
      end else if (r < 90) begin
         c = CMD_SETPOS;
         v = 32'hFFFF_FFFF - $urandom_range(0, 4);
      end else if (r >= 96) c = CMD_UNUSED;
      send_item(c, v, 1'b0, '0);
   endtask

   initial begin
      tick_report_type none;
      logic [TEMPO_W-1:0] b;
      logic [TEMPO_W-1:0] q;
      none = '0;
      m_bpm = TEMPO_W'(RESET_BPM);
      m_ppq = TEMPO_W'(RESET_PPQ);
      m_period = period_for(m_bpm, m_ppq);
      m_samples = '0;
      m_tick = '0;
      for (int i = 0; i < SLOTS; i++) begin
         m_busy[i] = 1'b0;
         m_target[i] = '0;
      end

      add_row(mk_row(ROW_ITEM, CMD_UNUSED, 32'hFFFF_FFFF, 16'd1, 1'b1,
                     report(32'h0, 1'b0, 1'b0, 4'd0, 1'b0)));
      add_row(mk_row(ROW_ITEM, CMD_SETPOS, 32'hFFFF_FFFF, 16'd1, 1'b1,
                     report(32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, 1'b0)));
      add_row(mk_row(ROW_ITEM, CMD_WAIT, 32'h0, 16'd1, 1'b1,
                     report(32'hFFFF_FFFF, 1'b0, 1'b1, 4'd0, 1'b0)));
      add_row(mk_row(ROW_ITEM, CMD_WAIT, 32'hFFFF_FFFF, 16'd1, 1'b1,
                     report(32'hFFFF_FFFF, 1'b0, 1'b1, 4'd0, 1'b0)));
      add_row(mk_row(ROW_ITEM, CMD_SETPOS, 32'hFFFF_FFFE, 16'd1, 1'b1,
                     report(32'hFFFF_FFFE, 1'b0, 1'b0, 4'd0, 1'b0)));
      add_row(mk_row(ROW_ITEM, CMD_WAIT, 32'hFFFF_FFFF, 16'd1, 1'b1,
                     report(32'hFFFF_FFFE, 1'b0, 1'b0, 4'd1, 1'b0)));
      add_row(mk_row(ROW_ITEM, CMD_SAMPLE, 32'hFFFF_FFFF, 16'd40, 1'b0, none));
      // shrink the period below the running sample count
      add_row(mk_row(ROW_CSR, REG_PPQ, 32'd1023, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_CSR, REG_BPM, 32'd1000, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_ITEM, CMD_SAMPLE, 32'h0, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_ITEM, CMD_SAMPLE, 32'h0, 16'd12, 1'b0, none));
      add_row(mk_row(ROW_ITEM, CMD_SETPOS, 32'h0, 16'd1, 1'b1,
                     report(32'h0, 1'b0, 1'b0, 4'd0, 1'b0)));
      add_row(mk_row(ROW_ITEM, CMD_WAIT, 32'h8000_0000, 16'd9, 1'b0, none));
      add_row(mk_row(ROW_ITEM, CMD_SETPOS, 32'h7FFF_FFFF, 16'd1, 1'b1,
                     report(32'h7FFF_FFFF, 1'b0, 1'b0, PEND_OUT_W'(SLOTS), 1'b0)));
      add_row(mk_row(ROW_ITEM, CMD_SAMPLE, 32'h0, 16'd6, 1'b0, none));
      add_row(mk_row(ROW_CSR, REG_BPM, 32'd0, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_CSR, REG_PPQ, 32'd1, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_ITEM, CMD_SAMPLE, 32'h5555_AAAA, 16'd5, 1'b0, none));
      add_row(mk_row(ROW_CSR, REG_SPARE2, 32'd1023, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_CSR, REG_SPARE3, 32'd0, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_ITEM, CMD_SAMPLE, 32'h0, 16'd3, 1'b0, none));
      add_row(mk_row(ROW_CSR, REG_BPM, 32'd1023, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_CSR, REG_PPQ, 32'd0, 16'd1, 1'b0, none));
      add_row(mk_row(ROW_ITEM, CMD_SAMPLE, 32'h0, 16'd4, 1'b0, none));

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      rx_mode = 1;
      foreach (stim_rows[k]) begin
         if (stim_rows[k].kind == ROW_CSR) begin
            write_tempo_reg(stim_rows[k].code, stim_rows[k].value[TEMPO_W-1:0]);
         end else begin
            repeat (stim_rows[k].reps) begin
               send_item(stim_rows[k].code, stim_rows[k].value, stim_rows[k].typed,
                         stim_rows[k].want);
               pace_sender();
            end
         end
      end

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin b = 10'd1000; q = 10'd1000; end
            1: begin b = 10'd0; q = 10'd1; end
            2: begin b = 10'd1023; q = 10'd300; end
            default: begin
               b = TEMPO_W'($urandom_range(300, 1000));
               q = TEMPO_W'($urandom_range(300, 1000));
            end
         endcase
         write_tempo_reg(REG_BPM, b);
         write_tempo_reg(REG_PPQ, q);
         rx_mode = (p == 4) ? 0 : p % 4;
         tx_gapless = (p == 3 || p == 4);
         if (p == 3) hold_asked = hold_asked + 1;
         for (int n = 0; n < 200; n++) begin
            if (p == 5 && n == 100) drain();
            send_random_item();
            pace_sender();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (failures == 0 && tick_reports_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
src/ttc_pkg.sv
src/ttc_ram.sv
src/ttc_div.sv
src/ttc_seq.sv
src/ttc_dp.sv
src/tempo_tick_clock_with_waiters_core.sv
test/tempo_tick_clock_with_waiters_core_tb.sv
